@@ hw/rtl/hrrn_pkg.sv @@
// Package for the HRRN/FIFO ready-list scheduler.
// Holds status codes, command codes and register indexes. No dependencies.
package hrrn_pkg;
    typedef logic [1:0] t_status;
    localparam t_status ST_ADDED  = 2'd0;
    localparam t_status ST_PICKED = 2'd1;
    localparam t_status ST_NONE   = 2'd2;
    localparam t_status ST_FULL   = 2'd3;
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_PICK = 1'b1;
    localparam logic CFG_POLICY = 1'b0;
    localparam logic CFG_ALPHA  = 1'b1;
    localparam logic [8:0] ALPHA_ONE = 9'd256;
endpackage

@@ hw/rtl/hrrn_mul.sv @@
// Shared 32x32 multiplier with registered product for the scheduler.
// Depends on nothing.
module hrrn_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;

    // one product per cycle, registered
    always_ff @(posedge i_clk) begin
        r_p <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = r_p;
endmodule

@@ hw/rtl/hrrn_fifo_ready_scheduler.sv @@
// Top level of the HRRN/FIFO ready-list scheduler.
// Uses hrrn_pkg and the shared multiplier hrrn_mul.
//
// Usage:
//   Input channel (i_valid/o_ready) carries one command: add or pick.
//   Output channel (o_valid/i_ready) returns one result per command.
//   Config channel (i_cfg_valid/o_cfg_ready) writes policy_mode (0) and
//   alpha (1); write only while the block is idle.
// Command flow:
//   Add and full-list add: the result is registered on acceptance. FIFO pick:
//   slot 0 is chosen, then the gap is closed. Keep pick: the entries are
//   searched in order for the first matching pid, then the gap is closed
//   behind the chosen one. HRRN pick: a smoothing pass over the list when a
//   pid was picked before, a ratio scan through the single shared multiplier,
//   then the gap close.
//   One command is worked on at a time; o_ready is low meanwhile.
// Reset: list emptied, last picked pid cleared, policy FIFO, alpha 128.
//   Entry stores are not cleared.
// Stall: a result waits in the output register until taken; the next
//   command is accepted from the cycle after the result is taken.
module hrrn_fifo_ready_scheduler
    import hrrn_pkg::*;
#(
    parameter int ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_cmd,
    input  logic [15:0] i_pid,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_estimate,
    input  logic [23:0] i_run_time,
    input  logic        i_keep_valid,
    input  logic [15:0] i_keep_pid,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_out_pid,
    output logic [31:0] o_out_estimate,
    output logic [4:0]  o_ready_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RD      = 4'd1;
    localparam logic [3:0] S_SM_CHK  = 4'd2;
    localparam logic [3:0] S_SM_M2   = 4'd3;
    localparam logic [3:0] S_SM_WR   = 4'd4;
    localparam logic [3:0] S_SC_M1   = 4'd5;
    localparam logic [3:0] S_SC_M2   = 4'd6;
    localparam logic [3:0] S_SC_CMP  = 4'd7;
    localparam logic [3:0] S_SEL     = 4'd8;
    localparam logic [3:0] S_SH_RD   = 4'd9;
    localparam logic [3:0] S_SH_WR   = 4'd10;
    localparam logic [3:0] S_DONE    = 4'd11;
    localparam logic [3:0] S_KEEP    = 4'd12;
    localparam logic [3:0] S_KEEP_RD = 4'd13;
    localparam logic [3:0] S_SM_RD   = 4'd14;
    localparam logic [3:0] S_SC_RD   = 4'd15;

    // entry stores
    logic [15:0] r_mem_pid [ENTRIES];
    logic [31:0] r_mem_arr [ENTRIES];
    logic [31:0] r_mem_est [ENTRIES];
    logic [23:0] r_mem_run [ENTRIES];

    logic [3:0]    r_state;
    logic [CW-1:0] r_total;
    logic          r_last_valid;
    logic [15:0]   r_last_pid;
    logic          r_policy;
    logic [8:0]    r_alpha;

    // latched command
    logic [31:0]   r_now;
    logic [15:0]   r_keep_pid;

    // scan state
    logic [CW-1:0] r_idx;
    logic [IW-1:0] r_sel;
    logic          r_found;
    logic [31:0]   r_best_w;
    logic [31:0]   r_best_e;
    logic [15:0]   r_rd_pid;
    logic [31:0]   r_rd_arr;
    logic [31:0]   r_rd_est;
    logic [23:0]   r_rd_run;
    logic [63:0]   r_prod;
    logic [15:0]   r_sel_pid;
    logic [31:0]   r_sel_est;

    // output register
    logic          r_ovalid;
    logic [1:0]    r_ostatus;
    logic [15:0]   r_opid;
    logic [31:0]   r_oest;
    logic [CW-1:0] r_ocount;

    // shared multiplier operands
    logic [31:0] w_ma;
    logic [31:0] w_mb;
    logic [63:0] w_mp;
    logic [8:0]  w_a;
    logic [31:0] w_cur_w;
    logic [31:0] w_cur_e;
    logic [IW-1:0] w_idx;
    logic [IW-1:0] w_idx1;
    logic [63:0] w_mix;

    assign w_idx   = r_idx[IW-1:0];
    assign w_idx1  = IW'(r_idx + CW'(1));
    assign w_a     = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign w_cur_w = r_now - r_rd_arr;
    assign w_cur_e = (r_rd_est == 32'd0) ? 32'd1 : r_rd_est;

    // operand selection for the shared multiplier
    always_comb begin
        w_ma = 32'd0;
        w_mb = 32'd0;
        unique case (r_state)
            S_SM_CHK: begin
                w_ma = {23'd0, w_a};
                w_mb = {r_rd_run, 8'd0};
            end
            S_SM_M2: begin
                w_ma = {23'd0, ALPHA_ONE - w_a};
                w_mb = r_rd_est;
            end
            S_SC_M1: begin
                w_ma = w_cur_w;
                w_mb = r_best_e;
            end
            S_SC_M2: begin
                w_ma = r_best_w;
                w_mb = w_cur_e;
            end
            default: begin
                w_ma = 32'd0;
                w_mb = 32'd0;
            end
        endcase
    end

    hrrn_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_mp)
    );

    assign w_mix = r_prod + w_mp;

    assign o_ready     = (r_state == S_IDLE) && !r_ovalid;
    assign o_cfg_ready = 1'b1;
    assign o_valid        = r_ovalid;
    assign o_status       = r_ostatus;
    assign o_out_pid      = r_opid;
    assign o_out_estimate = r_oest;
    assign o_ready_count  = 5'(r_ocount);

    // memory writes and reads; read data is registered from slot r_idx (slot r_idx+1 in S_SH_RD)
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && o_ready && i_cmd == CMD_ADD
            && r_total < CW'(ENTRIES)) begin
            r_mem_pid[r_total[IW-1:0]] <= i_pid;
            r_mem_arr[r_total[IW-1:0]] <= i_now_time;
            r_mem_est[r_total[IW-1:0]] <= i_estimate;
            r_mem_run[r_total[IW-1:0]] <= i_run_time;
        end else if (r_state == S_SM_WR) begin
            r_mem_est[w_idx] <= w_mix[39:8];
        end else if (r_state == S_SH_WR) begin
            r_mem_pid[w_idx] <= r_rd_pid;
            r_mem_arr[w_idx] <= r_rd_arr;
            r_mem_est[w_idx] <= r_rd_est;
            r_mem_run[w_idx] <= r_rd_run;
        end
        if (r_state == S_SH_RD) begin
            r_rd_pid <= r_mem_pid[w_idx1];
            r_rd_arr <= r_mem_arr[w_idx1];
            r_rd_est <= r_mem_est[w_idx1];
            r_rd_run <= r_mem_run[w_idx1];
        end else begin
            r_rd_pid <= r_mem_pid[w_idx];
            r_rd_arr <= r_mem_arr[w_idx];
            r_rd_est <= r_mem_est[w_idx];
            r_rd_run <= r_mem_run[w_idx];
        end
    end

    // sequencer; r_idx rests at zero while idle so slot 0 is already read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_total      <= '0;
            r_idx        <= '0;
            r_last_valid <= 1'b0;
            r_last_pid   <= 16'd0;
            r_policy     <= 1'b0;
            r_alpha      <= 9'd128;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_POLICY) r_policy <= i_cfg_data[0];
                else                           r_alpha  <= i_cfg_data;
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_now      <= i_now_time;
                        r_keep_pid <= i_keep_pid;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_sel      <= '0;
                        if (i_cmd == CMD_ADD) begin
                            r_ovalid <= 1'b1;
                            r_opid   <= 16'd0;
                            r_oest   <= 32'd0;
                            if (r_total < CW'(ENTRIES)) begin
                                r_total   <= r_total + CW'(1);
                                r_ocount  <= r_total + CW'(1);
                                r_ostatus <= ST_ADDED;
                            end else begin
                                r_ocount  <= r_total;
                                r_ostatus <= ST_FULL;
                            end
                        end else if (r_total == '0) begin
                            r_state <= S_DONE;
                        end else if (i_keep_valid) begin
                            r_state <= S_KEEP;
                        end else if (r_policy && r_last_valid) begin
                            r_state <= S_SM_CHK;
                        end else if (r_policy) begin
                            r_state <= S_RD;
                        end else begin
                            r_found <= 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                // keep path: first matching pid
                S_KEEP: begin
                    if (r_idx >= r_total) begin
                        r_state <= S_DONE;
                    end else if (r_rd_pid == r_keep_pid) begin
                        r_found <= 1'b1;
                        r_sel   <= w_idx;
                        r_state <= S_SEL;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_KEEP_RD;
                    end
                end
                S_KEEP_RD: r_state <= S_KEEP;
                // smoothing pass: product a*run now in multiplier
                S_SM_CHK: begin
                    if (r_idx >= r_total) begin
                        r_idx   <= '0;
                        r_state <= S_SC_RD;
                    end else if (r_rd_pid == r_last_pid) begin
                        r_state <= S_SM_M2;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SM_RD;
                    end
                end
                S_SM_M2: begin
                    r_prod  <= w_mp;
                    r_state <= S_SM_WR;
                end
                S_SM_WR: begin
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_SM_RD;
                end
                S_SM_RD: r_state <= S_SM_CHK;
                S_SC_RD: r_state <= S_RD;
                // read slot 0 as first best (FIFO: select it), then step the ratio scan
                S_RD: begin
                    if (!r_policy) begin
                        r_sel   <= '0;
                        r_state <= S_SEL;
                    end else if (r_idx == '0) begin
                        r_best_w <= w_cur_w;
                        r_best_e <= w_cur_e;
                        r_found  <= 1'b1;
                        r_sel    <= '0;
                        r_idx    <= CW'(1);
                    end else if (r_idx >= r_total) begin
                        r_state <= S_SEL;
                    end else begin
                        r_state <= S_SC_M1;
                    end
                end
                S_SC_M1: r_state <= S_SC_M2;
                S_SC_M2: begin
                    r_prod  <= w_mp;
                    r_state <= S_SC_CMP;
                end
                S_SC_CMP: begin
                    if (r_prod >= w_mp) begin
                        r_best_w <= w_cur_w;
                        r_best_e <= w_cur_e;
                        r_sel    <= w_idx;
                    end
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_RD;
                end
                // latch chosen entry, then close the gap
                S_SEL: begin
                    r_idx   <= CW'(r_sel);
                    r_state <= S_SH_RD;
                    r_sel_pid <= r_mem_pid[r_sel];
                    r_sel_est <= r_mem_est[r_sel];
                end
                S_SH_RD: begin
                    if (r_idx + CW'(1) >= r_total) r_state <= S_DONE;
                    else                           r_state <= S_SH_WR;
                end
                S_SH_WR: begin
                    r_idx   <= r_idx + CW'(1);
                    r_state <= S_SH_RD;
                end
                S_DONE: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                    r_idx    <= '0;
                    if (r_found) begin
                        r_total      <= r_total - CW'(1);
                        r_ocount     <= r_total - CW'(1);
                        r_ostatus    <= ST_PICKED;
                        r_opid       <= r_sel_pid;
                        r_oest       <= r_sel_est;
                        r_last_valid <= 1'b1;
                        r_last_pid   <= r_sel_pid;
                    end else begin
                        r_ocount  <= r_total;
                        r_ostatus <= ST_NONE;
                        r_opid    <= 16'd0;
                        r_oest    <= 32'd0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ dv/tb.sv @@
// Testbench for the HRRN/FIFO ready-list scheduler: directed then random commands,
// a self-contained scheduling predictor and an in-order result checker.
// Depends on hrrn_pkg and hrrn_fifo_ready_scheduler.
module tb;
    import hrrn_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic        cmd;
        logic [15:0] pid;
        logic [31:0] now_time;
        logic [31:0] estimate;
        logic [23:0] run_time;
        logic        keep_valid;
        logic [15:0] keep_pid;
    } t_command;

    typedef struct packed {
        t_status     status;
        logic [15:0] pid;
        logic [31:0] estimate;
        logic [4:0]  count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_cmd = CMD_ADD;
    logic [15:0] i_pid = '0;
    logic [31:0] i_now_time = '0;
    logic [31:0] i_estimate = '0;
    logic [23:0] i_run_time = '0;
    logic        i_keep_valid = 1'b0;
    logic [15:0] i_keep_pid = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [15:0] o_out_pid;
    logic [31:0] o_out_estimate;
    logic [4:0]  o_ready_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_POLICY;
    logic [8:0]  i_cfg_data = '0;

    hrrn_fifo_ready_scheduler #(.ENTRIES(DEPTH)) uut (.*);

    always #4 i_clk = ~i_clk;

    // scheduler shadow state
    logic        mode_hrrn;
    logic [8:0]  alpha_w;
    logic [15:0] sh_pid[$];
    logic [31:0] sh_arr[$];
    logic [31:0] sh_est[$];
    logic [23:0] sh_run[$];
    logic        last_ok;
    logic [15:0] last_id;

    t_command  pending_cmds[$];
    t_outcome  expected_outcomes[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        hold_cycles = 0;
    bit        failed = 0;
    int        cycles = 0;
    t_command  cur_cmd;
    logic      o_ready_q = 1'b0;

    // compute the outcome of one command and update the shadow list
    function automatic t_outcome schedule(t_command c);
        t_outcome r;
        int sel;
        bit hit;
        logic [63:0] a, lhs, rhs, wj, wb, ej, eb;
        r = '0;
        hit = 0;
        sel = 0;
        if (c.cmd == CMD_ADD) begin
            if (sh_pid.size() >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                sh_pid.push_back(c.pid);
                sh_arr.push_back(c.now_time);
                sh_est.push_back(c.estimate);
                sh_run.push_back(c.run_time);
                r.status = ST_ADDED;
            end
        end else begin
            if (c.keep_valid) begin
                for (int i = 0; i < sh_pid.size(); i++)
                    if (!hit && sh_pid[i] == c.keep_pid) begin
                        sel = i;
                        hit = 1;
                    end
            end else if (sh_pid.size() > 0) begin
                hit = 1;
                if (mode_hrrn) begin
                    a = (alpha_w > ALPHA_ONE) ? 64'd256 : 64'(alpha_w);
                    if (last_ok)
                        foreach (sh_pid[i])
                            if (sh_pid[i] == last_id)
                                sh_est[i] = 32'((a * (64'(sh_run[i]) << 8)
                                    + (64'd256 - a) * 64'(sh_est[i])) >> 8);
                    for (int i = 1; i < sh_pid.size(); i++) begin
                        wj = 64'(32'(c.now_time - sh_arr[i]));
                        wb = 64'(32'(c.now_time - sh_arr[sel]));
                        ej = (sh_est[i] == 0) ? 64'd1 : 64'(sh_est[i]);
                        eb = (sh_est[sel] == 0) ? 64'd1 : 64'(sh_est[sel]);
                        lhs = wj * eb;
                        rhs = wb * ej;
                        if (lhs >= rhs) sel = i;
                    end
                end
            end
            if (hit) begin
                r.status = ST_PICKED;
                r.pid = sh_pid[sel];
                r.estimate = sh_est[sel];
                sh_pid.delete(sel);
                sh_arr.delete(sel);
                sh_est.delete(sel);
                sh_run.delete(sel);
                last_ok = 1;
                last_id = r.pid;
            end else begin
                r.status = ST_NONE;
            end
        end
        r.count = 5'(sh_pid.size());
        return r;
    endfunction

    // driver: presents queued commands, predicts on acceptance
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready_q) begin
                expected_outcomes.push_back(schedule(cur_cmd));
                pending_cmds.pop_front();
            end
            if (pending_cmds.size() > 0 && !(i_valid && !o_ready_q)
                    && (i_valid || $urandom_range(99) >= send_idle_pct)) begin
                cur_cmd = pending_cmds[0];
                {i_cmd, i_pid, i_now_time, i_estimate, i_run_time, i_keep_valid,
                    i_keep_pid} = cur_cmd;
                i_valid <= 1'b1;
            end else if (!(i_valid && !o_ready_q)) begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) o_ready_q <= o_ready;

    // receiver stall and hold-off
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor: checks each result transaction against the oldest expectation
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t unexpected result status=%0d pid=%0d", $time, o_status,
                    o_out_pid);
                failed = 1;
            end else begin
                t_outcome e;
                e = expected_outcomes.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t status exp %0d got %0d", $time, e.status, o_status);
                    failed = 1;
                end
                if (o_out_pid !== e.pid) begin
                    $display("%0t pid exp %0d got %0d", $time, e.pid, o_out_pid);
                    failed = 1;
                end
                if (o_out_estimate !== e.estimate) begin
                    $display("%0t estimate exp %h got %h", $time, e.estimate,
                        o_out_estimate);
                    failed = 1;
                end
                if (o_ready_count !== e.count) begin
                    $display("%0t count exp %0d got %0d", $time, e.count, o_ready_count);
                    failed = 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic t_command add_cmd(logic [15:0] p, logic [31:0] t,
                                         logic [31:0] e, logic [23:0] r);
        t_command c;
        c = '0;
        c.cmd = CMD_ADD;
        c.pid = p;
        c.now_time = t;
        c.estimate = e;
        c.run_time = r;
        c.keep_pid = 16'($urandom);
        return c;
    endfunction

    function automatic t_command pick_cmd(logic [31:0] t, logic kv, logic [15:0] kp);
        t_command c;
        c = '0;
        c.cmd = CMD_PICK;
        c.now_time = t;
        c.keep_valid = kv;
        c.keep_pid = kp;
        c.pid = 16'($urandom);
        c.estimate = $urandom;
        c.run_time = 24'($urandom);
        return c;
    endfunction

    // wait for every result, then a pause for any trailing activity
    task automatic drain();
        while (pending_cmds.size() > 0 || i_valid || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [8:0] val);
        @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data <= val;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_POLICY) mode_hrrn = val[0];
        else alpha_w = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // random phase: burst of adds with picks mixed in
    task automatic random_phase(int n);
        logic [31:0] clock_now;
        logic [15:0] pids[$];
        clock_now = $urandom;
        for (int k = 0; k < n; k++) begin
            clock_now += $urandom_range(1000);
            if ($urandom_range(99) < 55) begin
                logic [15:0] p;
                p = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(20));
                pids.push_back(p);
                pending_cmds.push_back(add_cmd(p, ($urandom_range(19) == 0) ? $urandom
                    : clock_now - $urandom_range(5000),
                    ($urandom_range(9) == 0) ? $urandom : (($urandom_range(7) == 0) ? 0
                    : $urandom_range(100000)),
                    ($urandom_range(9) == 0) ? 24'($urandom) : 24'($urandom_range(500))));
            end else begin
                logic kv;
                logic [15:0] kp;
                kv = ($urandom_range(3) == 0);
                kp = (pids.size() > 0 && $urandom_range(3) != 0) ?
                    pids[$urandom_range(pids.size() - 1)] : 16'($urandom);
                pending_cmds.push_back(pick_cmd(clock_now, kv, kp));
            end
        end
    endtask

    initial begin
        mode_hrrn = 0;
        alpha_w = 9'd128;
        last_ok = 0;
        last_id = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty pick, field extremes, keep path, full list
        pending_cmds.push_back(pick_cmd(0, 0, 0));
        pending_cmds.push_back(pick_cmd(32'hFFFFFFFF, 1, 16'hFFFF));
        pending_cmds.push_back(add_cmd(16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF));
        pending_cmds.push_back(add_cmd(16'h0000, 0, 0, 0));
        for (int i = 0; i < 15; i++)
            pending_cmds.push_back(add_cmd(16'(i + 1), 32'(i * 10), 32'(i * 300), 24'(i)));
        pending_cmds.push_back(pick_cmd(100, 1, 16'd5));
        pending_cmds.push_back(pick_cmd(100, 1, 16'd999));
        pending_cmds.push_back(pick_cmd(100, 0, 0));
        drain();

        // HRRN with extreme alpha values, including saturation above one
        write_reg(CFG_POLICY, 9'd1);
        write_reg(CFG_ALPHA, 9'd511);
        for (int i = 0; i < 3; i++) pending_cmds.push_back(pick_cmd(32'd5000, 0, 0));
        drain();
        write_reg(CFG_ALPHA, 9'd0);
        for (int i = 0; i < 3; i++) pending_cmds.push_back(pick_cmd(32'd9000, 0, 0));
        drain();

        // random phases across settings and idle profiles
        send_idle_pct = 36; recv_idle_pct = 75;
        write_reg(CFG_ALPHA, 9'd256);
        random_phase(300);
        drain();
        write_reg(CFG_POLICY, 9'd0);
        random_phase(250);
        // long receiver hold-off while queued commands wait
        hold_cycles = 400;
        drain();
        send_idle_pct = 75; recv_idle_pct = 36;
        write_reg(CFG_POLICY, 9'd1);
        write_reg(CFG_ALPHA, 9'($urandom_range(256)));
        random_phase(300);
        drain();
        send_idle_pct = 0; recv_idle_pct = 0;
        write_reg(CFG_ALPHA, 9'd1);
        random_phase(400);
        drain();
        write_reg(CFG_ALPHA, 9'd300);
        random_phase(400);
        drain();

        if (!failed) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ files.f @@
hw/rtl/hrrn_pkg.sv
hw/rtl/hrrn_mul.sv
hw/rtl/hrrn_fifo_ready_scheduler.sv
dv/tb.sv
